// ===== rtl/rlpl_pkg.sv =====
// ============================================================================
// rlpl_pkg
// Shared types, constants and controller/datapath handshake structs for the
// longest-prefix route lookup unit.
// ============================================================================
`default_nettype none

package rlpl_pkg;

    // Default table depth
    localparam int TABLE_ENTRIES_DEF = 64;

    // Fixed field widths
    localparam int IDX_FIELD_W = 6;
    localparam int IP_W        = 32;
    localparam int PORT_W      = 8;
    localparam int CFG_W       = 7;

    // Item mode codes
    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    typedef struct packed {
        logic [IP_W-1:0]   prefix;
        logic [IP_W-1:0]   mask;
        logic [IP_W-1:0]   hop;
        logic [PORT_W-1:0] port;
    } route_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // Controller -> datapath
    typedef struct packed {
        logic wr_en;        // store the accepted entry
        logic start;        // latch destination and limit, clear best match
        logic rd_en;        // read the next table entry
        logic load_result;  // move best match into the result register
    } dp_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic zero_limit;   // no entries in use
        logic last_addr;    // current read address is the last one in use
        logic out_free;     // result register can take a new result
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/rlpl_channels.sv =====
// ============================================================================
// rlpl_channels
// Valid/ready channel interfaces: request, response and configuration.
// ============================================================================
`default_nettype none

interface rlpl_req_if;
    logic                            valid;
    logic                            ready;
    logic                            mode;
    logic [rlpl_pkg::IDX_FIELD_W-1:0] entry_index;
    logic [rlpl_pkg::IP_W-1:0]       route_prefix;
    logic [rlpl_pkg::IP_W-1:0]       route_mask;
    logic [rlpl_pkg::IP_W-1:0]       hop_address;
    logic [rlpl_pkg::PORT_W-1:0]     port_number;
    logic [rlpl_pkg::IP_W-1:0]       destination;

    modport source (
        output valid, mode, entry_index, route_prefix, route_mask,
               hop_address, port_number, destination,
        input  ready
    );
    modport sink (
        input  valid, mode, entry_index, route_prefix, route_mask,
               hop_address, port_number, destination,
        output ready
    );
endinterface

interface rlpl_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            hit;
    logic [rlpl_pkg::IP_W-1:0]       found_hop;
    logic [rlpl_pkg::PORT_W-1:0]     found_port;
    logic [rlpl_pkg::IDX_FIELD_W-1:0] found_index;

    modport source (
        output valid, hit, found_hop, found_port, found_index,
        input  ready
    );
    modport sink (
        input  valid, hit, found_hop, found_port, found_index,
        output ready
    );
endinterface

interface rlpl_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [rlpl_pkg::CFG_W-1:0] entries_in_use;

    modport source (
        output valid, entries_in_use,
        input  ready
    );
    modport sink (
        input  valid, entries_in_use,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/rlpl_ctrl.sv =====
// ============================================================================
// rlpl_ctrl
// Controller FSM: takes transactions, sequences the table scan and hands the
// best match to the result register.
// ============================================================================
`default_nettype none

module rlpl_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    input  wire logic                 req_mode,
    output logic                      req_ready,
    input  wire rlpl_pkg::dp_status_t status,
    output rlpl_pkg::dp_cmd_t         cmd
);

    rlpl_pkg::state_t state_reg;
    rlpl_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rlpl_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            rlpl_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (req_mode == rlpl_pkg::MODE_WRITE)
                    begin
                        cmd.wr_en = 1'b1;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        state_next = status.zero_limit ? rlpl_pkg::ST_FINISH
                                                       : rlpl_pkg::ST_SCAN;
                    end
                end
            end
            rlpl_pkg::ST_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (status.last_addr)
                begin
                    state_next = rlpl_pkg::ST_DRAIN;
                end
            end
            rlpl_pkg::ST_DRAIN:
            begin
                // last entry is compared in this cycle
                state_next = rlpl_pkg::ST_FINISH;
            end
            rlpl_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = rlpl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rlpl_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/rlpl_datapath.sv =====
// ============================================================================
// rlpl_datapath
// Route table memory, entry-count register, scan address counter, match
// compare stage, best-match registers and the result register.
// ============================================================================
`default_nettype none

module rlpl_datapath #(
    parameter int TABLE_ENTRIES = rlpl_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire rlpl_pkg::dp_cmd_t                cmd,
    output rlpl_pkg::dp_status_t                  status,
    // configuration
    input  wire logic                             cfg_valid,
    input  wire logic [rlpl_pkg::CFG_W-1:0]       cfg_entries,
    // request payload
    input  wire logic [rlpl_pkg::IDX_FIELD_W-1:0] entry_index,
    input  wire logic [rlpl_pkg::IP_W-1:0]        route_prefix,
    input  wire logic [rlpl_pkg::IP_W-1:0]        route_mask,
    input  wire logic [rlpl_pkg::IP_W-1:0]        hop_address,
    input  wire logic [rlpl_pkg::PORT_W-1:0]      port_number,
    input  wire logic [rlpl_pkg::IP_W-1:0]        destination,
    // response
    input  wire logic                             rsp_ready,
    output logic                                  rsp_valid,
    output logic                                  hit,
    output logic [rlpl_pkg::IP_W-1:0]             found_hop,
    output logic [rlpl_pkg::PORT_W-1:0]           found_port,
    output logic [rlpl_pkg::IDX_FIELD_W-1:0]      found_index
);

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int CNT_BIT = $clog2(TABLE_ENTRIES + 1);
    localparam int LIM_W   = (CNT_BIT > rlpl_pkg::CFG_W) ? CNT_BIT : rlpl_pkg::CFG_W;
    localparam logic [LIM_W-1:0] DEPTH = LIM_W'(TABLE_ENTRIES);

    rlpl_pkg::route_entry_t mem [TABLE_ENTRIES];

    logic [rlpl_pkg::CFG_W-1:0]  cfg_reg;
    logic [LIM_W-1:0]            limit_reg;
    logic [LIM_W-1:0]            cfg_limit;
    logic [IDX_W-1:0]            addr_reg;
    logic [rlpl_pkg::IP_W-1:0]   dest_reg;

    rlpl_pkg::route_entry_t      q_entry_reg;
    logic [IDX_W-1:0]            q_idx_reg;
    logic                        q_vld_reg;

    logic                        best_found_reg;
    logic [IDX_W-1:0]            best_idx_reg;
    logic [rlpl_pkg::IP_W-1:0]   best_mask_reg;
    logic [rlpl_pkg::IP_W-1:0]   best_hop_reg;
    logic [rlpl_pkg::PORT_W-1:0] best_port_reg;

    logic                        out_valid_reg;
    logic                        out_hit_reg;
    logic [rlpl_pkg::IP_W-1:0]   out_hop_reg;
    logic [rlpl_pkg::PORT_W-1:0] out_port_reg;
    logic [rlpl_pkg::IDX_FIELD_W-1:0] out_idx_reg;

    logic                        wr_in_range;
    logic                        match;
    logic                        better;
    rlpl_pkg::route_entry_t      wr_entry;

    // entries_in_use above the table depth counts as the full table
    assign cfg_limit   = (LIM_W'(cfg_reg) > DEPTH) ? DEPTH : LIM_W'(cfg_reg);
    assign wr_in_range = LIM_W'(entry_index) < DEPTH;

    assign wr_entry.prefix = route_prefix;
    assign wr_entry.mask   = route_mask;
    assign wr_entry.hop    = hop_address;
    assign wr_entry.port   = port_number;

    assign status.zero_limit = (cfg_reg == '0);
    assign status.last_addr  = (LIM_W'(addr_reg) + LIM_W'(1)) == limit_reg;
    assign status.out_free   = !out_valid_reg || rsp_ready;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            cfg_reg <= cfg_entries;
        end
    end

    // table memory: write port and registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && wr_in_range)
        begin
            mem[IDX_W'(entry_index)] <= wr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            q_entry_reg <= mem[addr_reg];
        end
    end

    // scan address and lookup context
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg  <= '0;
            limit_reg <= '0;
            q_vld_reg <= 1'b0;
            q_idx_reg <= '0;
        end
        else
        begin
            q_vld_reg <= cmd.rd_en;
            if (cmd.rd_en)
            begin
                q_idx_reg <= addr_reg;
            end
            if (cmd.start)
            begin
                addr_reg  <= '0;
                limit_reg <= cfg_limit;
            end
            else if (cmd.rd_en)
            begin
                addr_reg <= addr_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            dest_reg <= destination;
        end
    end

    // compare stage: strict > keeps the lowest index on equal masks
    assign match  = ((dest_reg ^ q_entry_reg.prefix) & q_entry_reg.mask) == '0;
    assign better = !best_found_reg || (q_entry_reg.mask > best_mask_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_found_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            best_found_reg <= 1'b0;
        end
        else if (q_vld_reg && match)
        begin
            best_found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_vld_reg && match && better)
        begin
            best_idx_reg  <= q_idx_reg;
            best_mask_reg <= q_entry_reg.mask;
            best_hop_reg  <= q_entry_reg.hop;
            best_port_reg <= q_entry_reg.port;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            out_hit_reg  <= best_found_reg;
            out_hop_reg  <= best_found_reg ? best_hop_reg  : '0;
            out_port_reg <= best_found_reg ? best_port_reg : '0;
            out_idx_reg  <= best_found_reg ? rlpl_pkg::IDX_FIELD_W'(best_idx_reg) : '0;
        end
    end

    assign rsp_valid   = out_valid_reg;
    assign hit         = out_hit_reg;
    assign found_hop   = out_hop_reg;
    assign found_port  = out_port_reg;
    assign found_index = out_idx_reg;

endmodule

`default_nettype wire

// ===== rtl/route_longest_prefix_lookup_unit.sv =====
// ============================================================================
// route_longest_prefix_lookup_unit
// IPv4 longest-prefix route lookup over a table held in one memory.
// ============================================================================
// Write transaction: stored at the acceptance edge, no response.
// Lookup transaction: the scan covers N = min(entries_in_use, TABLE_ENTRIES)
//   entries and reads one entry a cycle through the single memory read port.
//   No new request is taken until the result is loaded. With no entries in
//   use the response is a miss. A response still pending holds the unit
//   until it drains.
// Reset: FSM, entry count and result register clear; table contents stay
//   undefined until written (no clearing pass). Config is always ready.
// ============================================================================
`default_nettype none

module route_longest_prefix_lookup_unit #(
    parameter int TABLE_ENTRIES = rlpl_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rlpl_req_if.sink   req,
    rlpl_rsp_if.source rsp,
    rlpl_cfg_if.sink   cfg
);

    rlpl_pkg::dp_cmd_t    cmd;
    rlpl_pkg::dp_status_t status;

    // config register sits in the datapath; the entry count is latched when a
    // lookup starts, so a write only affects later lookups
    assign cfg.ready = 1'b1;

    // Controller: request handshake and scan sequencing
    rlpl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_mode  (req.mode),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: table memory, compare stage, best match, result register
    rlpl_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_valid    (cfg.valid),
        .cfg_entries  (cfg.entries_in_use),
        .entry_index  (req.entry_index),
        .route_prefix (req.route_prefix),
        .route_mask   (req.route_mask),
        .hop_address  (req.hop_address),
        .port_number  (req.port_number),
        .destination  (req.destination),
        .rsp_ready    (rsp.ready),
        .rsp_valid    (rsp.valid),
        .hit          (rsp.hit),
        .found_hop    (rsp.found_hop),
        .found_port   (rsp.found_port),
        .found_index  (rsp.found_index)
    );

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // a pending response is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |-> status.out_free)
        else $error("result loaded while previous response still pending");

    // no request is taken while the scan is running
    a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> !req.ready)
        else $error("request ready during table scan");

    // commands are mutually exclusive
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.wr_en, cmd.start, cmd.rd_en, cmd.load_result}))
        else $error("overlapping datapath commands");

    // a miss carries all-zero fields
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.hit) |->
            (rsp.found_hop == '0 && rsp.found_port == '0 && rsp.found_index == '0))
        else $error("miss response with nonzero fields");

endmodule

`default_nettype wire
